/* hdl/wlbc_pkg.sv */
// package: types, constants and helpers for the wheel-leg balance controller
package wlbc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = 32;

  localparam logic signed [W-1:0] FX_ONE  = W'(64'sd1 << FRAC_BITS);
  localparam logic signed [W-1:0] FX_HALF = W'(((64'sd1 << FRAC_BITS) + 1) / 2);

  localparam logic signed [W-1:0] C_095  = W'(((64'sd95 << FRAC_BITS) + 50) / 100);
  localparam logic signed [W-1:0] C_005  = W'(((64'sd5 << FRAC_BITS) + 50) / 100);
  localparam logic signed [W-1:0] C_0005 = W'(((64'sd5 << FRAC_BITS) + 500) / 1000);
  localparam logic signed [W-1:0] C_02   = W'(((64'sd2 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_004  = W'(((64'sd4 << FRAC_BITS) + 50) / 100);
  localparam logic signed [W-1:0] C_01   = W'(((64'sd1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_0009 = W'(((64'sd9 << FRAC_BITS) + 500) / 1000);
  localparam logic signed [W-1:0] C_100  = W'(64'sd100 << FRAC_BITS);
  localparam logic signed [W-1:0] C_4    = W'(64'sd4 << FRAC_BITS);
  localparam logic signed [W-1:0] C_015  = W'(((64'sd15 << FRAC_BITS) + 50) / 100);
  localparam logic signed [W-1:0] C_09   = W'(((64'sd9 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_N06  = -W'(((64'sd6 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_06   = W'(((64'sd6 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_03   = W'(((64'sd3 << FRAC_BITS) + 5) / 10);
  localparam logic signed [W-1:0] C_105  = W'(((64'sd105 << FRAC_BITS) + 50) / 100);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 26;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROUCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_END   = 3'd5;

  typedef struct packed {
    logic [0:0]         opcode;
    logic signed [31:0] fwd_velocity;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] cmd_speed;
    logic signed [31:0] cmd_jump;
    logic signed [31:0] cmd_height;
    logic signed [31:0] cmd_roll;
    logic signed [31:0] cmd_turn;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_wheel;
    logic signed [31:0] right_wheel;
    logic signed [31:0] hip_right;
    logic signed [31:0] hip_left;
    logic signed [31:0] knee_right;
    logic signed [31:0] knee_left;
  } out_item_t;

  // datapath micro-operations, one per step of a tick or command
  typedef enum logic [4:0] {
    OP_NONE, OP_CMD, OP_LOAD, OP_SS1, OP_SS2, OP_VE, OP_VI, OP_DP1, OP_DP2,
    OP_PE, OP_PI, OP_KP, OP_DV1, OP_DV2, OP_DV3, OP_HW, OP_TW, OP_JUMP,
    OP_HL, OP_DRL, OP_JR1, OP_JR2, OP_JR3, OP_JR4, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [W+1:0] v);
    if (v > $signed({3'b000, {(W-1){1'b1}}})) return {1'b0, {(W-1){1'b1}}};
    if (v < $signed({3'b111, {(W-1){1'b0}}})) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clampv(input logic signed [W+1:0] v,
      input logic signed [W+1:0] lo, input logic signed [W+1:0] hi);
    if (v > hi) return W'(hi);
    if (v < lo) return W'(lo);
    return v[W-1:0];
  endfunction

endpackage

/* hdl/wlbc_stream_if.sv */
// valid/ready stream interface for item and result channels
interface wlbc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/wlbc_datapath.sv */
// datapath: state registers, one shared multiplier and accumulator
module wlbc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  wlbc_pkg::dp_cmd_t   cmd,
  input  wlbc_pkg::in_item_t  item,
  input  logic                cfg_we,
  input  logic [wlbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wlbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output wlbc_pkg::out_item_t result
);
  import wlbc_pkg::*;

  logic [25:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [22:0] integ_lim_r;
  logic [11:0] crouch_r, jend_r, jticks_r;
  logic jact_r;
  logic signed [W-1:0] ss_r, vi_r, pi_r, spd_r, trn_r, hgt_r, roll_r, svh_r;
  logic signed [W-1:0] vel_r, pit_r, prt_r, ve_r, dp_r, pe_r, kp_r, dv_r, hw_r, tw_r;
  logic signed [W-1:0] hl_r, dr_r, dl_r;
  // wide accumulator so multi-term sums saturate only once
  logic signed [W+1:0] acc_r;
  out_item_t res_r;

  // multiplier operands and registered product
  logic signed [W-1:0] ma, mb, p_r;
  logic signed [2*W:0] prod;
  logic signed [W-1:0] prod_q;
  dp_op_t op_d_r;

  function automatic logic signed [W+1:0] clampv_wide(input logic signed [2*W:0] v);
    if (v > (2*W+1)'(64'sh7FFF_FFFF)) return (W+2)'(64'sh7FFF_FFFF) + 1;
    if (v < -(2*W+1)'(64'sh8000_0000)) return -(W+2)'(64'sh8000_0000) - 1;
    return v[W+1:0];
  endfunction

  always_comb begin
    ma = '0; mb = '0;
    case (cmd.op)
      OP_SS1: begin ma = C_095; mb = ss_r; end
      OP_SS2: begin ma = C_005; mb = spd_r; end
      OP_VI:  begin ma = C_0005; mb = ve_r; end
      OP_DP1: begin ma = C_004; mb = ss_r; end
      OP_DP2: begin ma = C_01; mb = vi_r; end
      OP_PI:  begin ma = C_0009; mb = pe_r; end
      OP_KP:  begin ma = C_100; mb = (pit_r[W-1]) ? sat32(-(W+2)'(pit_r)) : pit_r; end
      OP_DV1: begin ma = kp_r; mb = pe_r; end
      OP_DV2: begin ma = W'({6'd0, integ_gain_r}); mb = pi_r; end
      OP_DV3: begin ma = W'({6'd0, deriv_gain_r}); mb = prt_r; end
      OP_HW:  begin ma = FX_HALF; mb = dv_r; end
      OP_TW:  begin ma = C_4; mb = trn_r; end
      OP_HL:  begin ma = FX_HALF; mb = roll_r; end
      OP_JR1: begin ma = C_N06; mb = dr_r; end
      OP_JR2: begin ma = C_N06; mb = dl_r; end
      OP_JR3: begin ma = C_105; mb = dr_r; end
      OP_JR4: begin ma = C_105; mb = dl_r; end
      default: ;
    endcase
  end

  // rounding half up then floor equals arithmetic shift after adding half lsb
  logic signed [2*W:0] prod_rnd;
  logic signed [2*W:0] prod_sh;
  always_comb begin
    prod     = (2*W+1)'(ma) * (2*W+1)'(mb);
    prod_rnd = prod + ((2*W+1)'(1) <<< (FRAC_BITS-1));
    prod_sh  = prod_rnd >>> FRAC_BITS;
    prod_q   = sat32((W+2)'(clampv_wide(prod_sh)));
  end

  logic [12:0] n_w;
  assign n_w = {1'b0, jticks_r} + 13'd1;

  logic signed [W+1:0] sum_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= 26'd16384000; integ_gain_r <= 26'd4587520;
      deriv_gain_r <= 26'd655360; integ_lim_r <= 23'd655360;
      crouch_r <= 12'd1200; jend_r <= 12'd1260;
      ss_r <= '0; vi_r <= '0; pi_r <= '0; spd_r <= '0; trn_r <= '0;
      hgt_r <= FX_HALF; roll_r <= '0; svh_r <= FX_HALF;
      jact_r <= 1'b0; jticks_r <= '0;
      op_d_r <= OP_NONE;
    end else begin
      op_d_r <= cmd.op;
      if (cfg_we) begin
        case (cfg_idx)
          REG_PROP_GAIN:  prop_gain_r <= cfg_data;
          REG_INTEG_GAIN: integ_gain_r <= cfg_data;
          REG_DERIV_GAIN: deriv_gain_r <= cfg_data;
          REG_INTEG_LIM:  integ_lim_r <= cfg_data[22:0];
          REG_CROUCH:     crouch_r <= cfg_data[11:0];
          REG_JUMP_END:   jend_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_CMD: begin
          if (item.cmd_jump > FX_ONE && !jact_r) begin
            jact_r <= 1'b1; jticks_r <= '0; svh_r <= hgt_r; roll_r <= '0;
          end else begin
            spd_r  <= clampv((W+2)'(item.cmd_speed), -(W+2)'(C_03), (W+2)'(C_03));
            hgt_r  <= clampv((W+2)'(item.cmd_height) + (W+2)'(FX_HALF), '0,
                             (W+2)'(FX_ONE));
            roll_r <= clampv((W+2)'(item.cmd_roll), -(W+2)'(C_06), (W+2)'(C_06));
            trn_r  <= clampv((W+2)'(item.cmd_turn), -(W+2)'(C_03), (W+2)'(C_03));
          end
        end
        OP_JUMP: begin
          if (jact_r) begin
            if (n_w > {1'b0, jend_r}) begin
              hgt_r <= svh_r; jticks_r <= '0; jact_r <= 1'b0;
            end else begin
              hgt_r <= (n_w > {1'b0, crouch_r}) ? C_09 : C_015;
              jticks_r <= n_w[12] ? 12'hFFF : n_w[11:0];
            end
          end
        end
        default: ;
      endcase
      // results of the previous multiply step land here
      case (op_d_r)
        OP_SS2: ss_r <= sat32(acc_r + (W+2)'(p_r));
        OP_VI:  vi_r <= clampv((W+2)'(vi_r) + (W+2)'(p_r), -(W+2)'(C_02), (W+2)'(C_02));
        OP_PI:  pi_r <= clampv((W+2)'(pi_r) + (W+2)'(p_r),
                               -(W+2)'({1'b0, integ_lim_r}), (W+2)'({1'b0, integ_lim_r}));
        default: ;
      endcase
    end
  end

  assign sum_w = acc_r;

  always_ff @(posedge clk) begin
    p_r <= prod_q;
    case (cmd.op)
      OP_LOAD: begin vel_r <= item.fwd_velocity; pit_r <= item.pitch_angle;
                     prt_r <= item.pitch_rate; end
      OP_VE:   ve_r <= sat32((W+2)'(vel_r) - (W+2)'(ss_r));
      OP_PE:   pe_r <= sat32((W+2)'(pit_r) - (W+2)'(dp_r));
      OP_DRL: begin
        dr_r <= sat32((W+2)'(hgt_r) - (W+2)'(hl_r) - (W+2)'(FX_HALF));
        dl_r <= sat32((W+2)'(hgt_r) + (W+2)'(hl_r) - (W+2)'(FX_HALF));
      end
      OP_OUT: begin
        res_r.left_wheel  <= sat32((W+2)'(hw_r) - (W+2)'(tw_r));
        res_r.right_wheel <= sat32((W+2)'(hw_r) + (W+2)'(tw_r));
      end
      default: ;
    endcase
    case (op_d_r)
      OP_SS1: acc_r <= (W+2)'(p_r);
      OP_DP1: acc_r <= (W+2)'(p_r) - (W+2)'(ve_r);
      OP_DP2: dp_r <= sat32(sum_w - (W+2)'(p_r));
      OP_KP:  kp_r <= sat32((W+2)'({1'b0, prop_gain_r}) + (W+2)'(p_r));
      OP_DV1: acc_r <= (W+2)'(p_r);
      OP_DV2: acc_r <= sum_w + (W+2)'(p_r);
      OP_DV3: dv_r <= sat32(sum_w + (W+2)'(p_r));
      OP_HW:  hw_r <= p_r;
      OP_TW:  tw_r <= p_r;
      OP_HL:  hl_r <= p_r;
      OP_JR1: res_r.hip_right <= p_r;
      OP_JR2: res_r.hip_left <= p_r;
      OP_JR3: res_r.knee_right <= p_r;
      OP_JR4: res_r.knee_left <= p_r;
      default: ;
    endcase
  end

  assign result = res_r;

endmodule

/* hdl/wlbc_ctrl.sv */
// controller: sequences datapath steps and runs the handshakes
module wlbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wlbc_pkg::dp_cmd_t cmd
);
  import wlbc_pkg::*;

  typedef enum logic [1:0] { S_IDLE, S_RUN, S_LAST } state_t;
  state_t state_r;
  logic   ov_r;

  logic [4:0] pc_r;
  localparam dp_op_t SEQ [0:22] = '{OP_LOAD, OP_SS1, OP_SS2, OP_NONE, OP_VE, OP_VI,
    OP_DP1, OP_NONE, OP_DP2, OP_NONE, OP_PE, OP_PI, OP_KP, OP_NONE, OP_DV1,
    OP_DV2, OP_DV3, OP_NONE, OP_HW, OP_TW, OP_JUMP, OP_HL, OP_NONE};
  localparam dp_op_t TAIL [0:5] = '{OP_DRL, OP_JR1, OP_JR2, OP_JR3, OP_JR4, OP_OUT};
  logic [2:0] tc_r;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) cmd.op = in_opcode ? OP_CMD : OP_LOAD;
      S_RUN:  cmd.op = SEQ[pc_r];
      // tail writes the output register, so it waits for a free slot
      S_LAST: if (!ov_r) cmd.op = TAIL[tc_r];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pc_r <= '0; tc_r <= '0; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !in_opcode) begin state_r <= S_RUN; pc_r <= 5'd1; end
        S_RUN: begin
          if (pc_r == 5'd22) begin state_r <= S_LAST; tc_r <= '0; end
          else pc_r <= pc_r + 5'd1;
        end
        S_LAST: begin
          if (!ov_r) begin
            if (tc_r == 3'd5) begin state_r <= S_IDLE; ov_r <= 1'b1; end
            else tc_r <= tc_r + 3'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/wheel_leg_balance_controller.sv */
// top level of the wheel-leg balance controller
// usage:
//   in channel carries one item: a command event (opcode 1) or a control tick
//   (opcode 0) with a sensor sample, all values signed Q16.16.
//   a command is applied at its transfer and gives no result.
//   a tick gives one result on the out channel: two wheel speeds and four
//   joint positions; out_valid rises after the last tail step; the steps
//   go one after another through a single shared 32x32 multiplier.
//   in_ready is high only between items; the next item is taken only once
//   a tick has run all its steps; one command per cycle while idle.
//   the result stays in the output register until the sink takes it; while
//   it waits the next tick may run but its final writes hold until the
//   register frees, which adds the stall length to that tick.
//   cfg port writes a register by index; the user writes only while idle, and
//   the block does not enforce it. synchronous reset restores gains, limits
//   and controller state; in_ready stays low while reset is asserted.
module wheel_leg_balance_controller (
  input  logic clk,
  input  logic rst_n,
  wlbc_stream_if.sink   in_if,
  wlbc_stream_if.source out_if,
  input  logic cfg_we,
  input  logic [wlbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wlbc_pkg::*;

  dp_cmd_t  cmd;
  in_item_t item;
  out_item_t res;

  assign item = in_if.data;

  wlbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_if.valid), .in_opcode(item.opcode),
    .in_ready(in_if.ready), .out_valid(out_if.valid), .out_ready(out_if.ready),
    .cmd(cmd));

  wlbc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data), .result(res));

  assign out_if.data = res;

endmodule

/* tb/wheel_leg_balance_controller_test.sv */
// testbench for the wheel-leg balance controller: tasks drive ticks and commands, results checked
`timescale 1ns / 100ps

module wheel_leg_balance_controller_test;
  import wlbc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam logic OPC_TICK = 1'b0;
  localparam logic OPC_CMD = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wlbc_stream_if #(.payload_t(in_item_t)) in_ch ();
  wlbc_stream_if #(.payload_t(out_item_t)) out_ch ();

  wheel_leg_balance_controller dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  longint g_prop, g_integ, g_deriv, g_ilim, g_crouch, g_jend;
  longint s_smooth, s_vint, s_pint, s_speed, s_turn, s_height, s_roll, s_saved;
  bit s_jump;
  longint s_jticks;

  out_item_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_ticks = 0;
  int n_cmds = 0;
  int n_jumps = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_off = 0;

  function automatic longint cfx(longint n, longint d);
    return (n * 65536 + d / 2) / d;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // rounded half up product, saturated
  function automatic longint qmul(longint a, longint b);
    longint x;
    x = a * b + 32768;
    return sat(x >>> 16);
  endfunction

  task automatic reset_predictor();
    g_prop = 16384000; g_integ = 4587520; g_deriv = 655360; g_ilim = 655360;
    g_crouch = 1200; g_jend = 1260;
    s_smooth = 0; s_vint = 0; s_pint = 0; s_speed = 0; s_turn = 0;
    s_height = cfx(1, 2); s_roll = 0; s_jump = 0; s_jticks = 0; s_saved = cfx(1, 2);
  endtask

  task automatic predict_balance(input in_item_t it);
    longint half, pitch, ve, dp, pe, absp, kp, dv, hw, tw, hl, dr, dl, n;
    out_item_t r;
    half = cfx(1, 2);
    if (it.opcode == OPC_CMD) begin
      n_cmds++;
      if (longint'(it.cmd_jump) > 65536 && !s_jump) begin
        s_jump = 1; s_jticks = 0; s_saved = s_height; s_roll = 0; n_jumps++;
        return;
      end
      s_speed = clip(longint'(it.cmd_speed), -cfx(3, 10), cfx(3, 10));
      s_height = clip(longint'(it.cmd_height) + half, 0, 65536);
      s_roll = clip(longint'(it.cmd_roll), -cfx(6, 10), cfx(6, 10));
      s_turn = clip(longint'(it.cmd_turn), -cfx(3, 10), cfx(3, 10));
      return;
    end
    n_ticks++;
    pitch = longint'(it.pitch_angle);
    s_smooth = sat(qmul(cfx(95, 100), s_smooth) + qmul(cfx(5, 100), s_speed));
    ve = sat(longint'(it.fwd_velocity) - s_smooth);
    s_vint = clip(s_vint + qmul(cfx(5, 1000), ve), -cfx(2, 10), cfx(2, 10));
    dp = sat(qmul(cfx(4, 100), s_smooth) - ve - qmul(cfx(1, 10), s_vint));
    pe = sat(pitch - dp);
    s_pint = clip(s_pint + qmul(cfx(9, 1000), pe), -g_ilim, g_ilim);
    absp = sat(pitch < 0 ? -pitch : pitch);
    kp = sat(g_prop + qmul(cfx(100, 1), absp));
    dv = sat(qmul(kp, pe) + qmul(g_integ, s_pint) +
             qmul(g_deriv, longint'(it.pitch_rate)));
    hw = qmul(half, dv);
    tw = qmul(cfx(4, 1), s_turn);
    if (s_jump) begin
      n = s_jticks + 1;
      s_height = cfx(15, 100);
      if (n > g_crouch) s_height = cfx(9, 10);
      if (n > g_jend) begin
        s_height = s_saved; s_jticks = 0; s_jump = 0;
      end else begin
        s_jticks = n > 4095 ? 4095 : n;
      end
    end
    hl = qmul(half, s_roll);
    dr = sat(s_height - hl - half);
    dl = sat(s_height + hl - half);
    r.left_wheel = 32'(sat(hw - tw));
    r.right_wheel = 32'(sat(hw + tw));
    r.hip_right = 32'(qmul(-cfx(6, 10), dr));
    r.hip_left = 32'(qmul(-cfx(6, 10), dl));
    r.knee_right = 32'(qmul(cfx(105, 100), dr));
    r.knee_left = 32'(qmul(cfx(105, 100), dl));
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result sink with random stalls and a long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_off <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data.left_wheel !== want.left_wheel)
          report_mismatch("left_wheel", out_ch.data.left_wheel, want.left_wheel);
        if (out_ch.data.right_wheel !== want.right_wheel)
          report_mismatch("right_wheel", out_ch.data.right_wheel, want.right_wheel);
        if (out_ch.data.hip_right !== want.hip_right)
          report_mismatch("hip_right", out_ch.data.hip_right, want.hip_right);
        if (out_ch.data.hip_left !== want.hip_left)
          report_mismatch("hip_left", out_ch.data.hip_left, want.hip_left);
        if (out_ch.data.knee_right !== want.knee_right)
          report_mismatch("knee_right", out_ch.data.knee_right, want.knee_right);
        if (out_ch.data.knee_left !== want.knee_left)
          report_mismatch("knee_left", out_ch.data.knee_left, want.knee_left);
      end
    end
  end

  // offer one item, idle at random first, hold until transfer
  task automatic send_item(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_balance(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic in_item_t make_tick(input logic [31:0] v, p, r);
    in_item_t it;
    it = '0;
    it.opcode = OPC_TICK; it.fwd_velocity = v; it.pitch_angle = p; it.pitch_rate = r;
    it.cmd_speed = $urandom; it.cmd_jump = $urandom; it.cmd_height = $urandom;
    it.cmd_roll = $urandom; it.cmd_turn = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_cmd(input logic [31:0] sp, jmp, h, rl, tn);
    in_item_t it;
    it.opcode = OPC_CMD; it.fwd_velocity = $urandom; it.pitch_angle = $urandom;
    it.pitch_rate = $urandom;
    it.cmd_speed = sp; it.cmd_jump = jmp; it.cmd_height = h; it.cmd_roll = rl;
    it.cmd_turn = tn;
    return it;
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN: g_prop = val & 64'h3FFFFFF;
      REG_INTEG_GAIN: g_integ = val & 64'h3FFFFFF;
      REG_DERIV_GAIN: g_deriv = val & 64'h3FFFFFF;
      REG_INTEG_LIM: g_ilim = val & 64'h7FFFFF;
      REG_CROUCH: g_crouch = val & 64'hFFF;
      REG_JUMP_END: g_jend = val & 64'hFFF;
      default: ;
    endcase
  endtask

  task automatic test_directed_extremes();
    send_item(make_tick(0, 0, 0));
    send_item(make_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(make_tick(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff));
    send_item(make_cmd(32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_tick(100, -200, 300));
    send_item(make_cmd(32'h8000_0000, 65536, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(make_tick(5000, 8000, -7000));
    send_item(make_cmd(20000, 32'h8000_0000, 16000, -30000, 12000));
    send_item(make_tick(-3000, 1000, 4000));
    // jump exactly at 1.0 does not start, just above does
    send_item(make_cmd(0, 65537, 0, 0, 0));
    send_item(make_cmd(0, 32'h7fff_ffff, 32000, 0, 0));
    repeat (4) send_item(make_tick(rand_word(), rand_word(), rand_word()));
  endtask

  task automatic test_jump_sequence(input longint crouch, input longint jend);
    int k;
    wait_idle();
    write_reg(REG_CROUCH, crouch);
    write_reg(REG_JUMP_END, jend);
    send_item(make_cmd($urandom_range(40000), 0, $urandom_range(60000), 20000, 9000));
    send_item(make_cmd(0, 32'h0002_0000, 0, 0, 0));
    for (k = 0; k < jend + 3; k++)
      send_item(make_tick($urandom_range(4000), $urandom_range(3000), $urandom_range(5000)));
  endtask

  task automatic test_gain_settings(input longint p, i, d, lim, int count);
    int k;
    wait_idle();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_INTEG_LIM, lim);
    write_reg(REG_UNUSED, $urandom);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 20)
        send_item(make_cmd(rand_word(), $urandom_range(3) == 0 ? rand_word() : 0,
                           rand_word(), rand_word(), rand_word()));
      else
        send_item(make_tick(rand_word(), rand_word(), rand_word()));
    end
  endtask

  task automatic test_backpressure();
    int k;
    wait_idle();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (k = 0; k < 8; k++) send_item(make_tick(rand_word(), rand_word(), rand_word()));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    reset_predictor();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_gain_settings(16384000, 4587520, 655360, 655360, 120);
    test_gain_settings(0, 0, 0, 0, 60);
    test_gain_settings(65536000, 65536000, 65536000, 6553600, 80);
    test_jump_sequence(3, 7);
    test_jump_sequence(9, 4);
    test_jump_sequence(1, 1);
    test_backpressure();
    no_idle = 1'b1;
    test_gain_settings($urandom_range(65536000), $urandom_range(65536000),
                       $urandom_range(65536000), $urandom_range(6553600), 120);
    no_idle = 1'b0;
    test_gain_settings($urandom, $urandom, $urandom, $urandom, 220);
    wait_idle();
    repeat (60) @(posedge clk);
    $display("covered %0d ticks, %0d commands, %0d jumps; %0d results checked",
             n_ticks, n_cmds, n_jumps, n_results);
    $display("register extremes, jump timing edges and a long output stall were exercised");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/wlbc_pkg.sv
hdl/wlbc_stream_if.sv
hdl/wlbc_datapath.sv
hdl/wlbc_ctrl.sv
hdl/wheel_leg_balance_controller.sv
tb/wheel_leg_balance_controller_test.sv
